>>> design/wnm_pkg.sv
// ----------------------------------------------------------------------------
// wnm_pkg: shared definitions for the wildcard name matcher
// Holds the default pattern bound, the special pattern symbols and the
// character folding function used on both pattern and name bytes.
// ----------------------------------------------------------------------------
package wnm_pkg;

    localparam int MAX_PATTERN_DEF = 64;

    localparam logic [7:0] SYM_STAR      = 8'h2A;
    localparam logic [7:0] SYM_ANY       = 8'h3F;
    localparam logic [7:0] SYM_SLASH     = 8'h2F;
    localparam logic [7:0] SYM_BACKSLASH = 8'h5C;
    localparam logic [7:0] SYM_UPPER_A   = 8'h41;
    localparam logic [7:0] SYM_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_NAME    = 1'b1;

    // Folds ASCII upper case to lower case and a slash to a backslash.
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == SYM_SLASH)
        begin
            r = SYM_BACKSLASH;
        end
        else if (c >= SYM_UPPER_A && c <= SYM_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

>>> design/wildcard_name_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_name_matcher: glob pattern match of streamed names
// Loads a pattern with '*' and '?' one byte per transfer, then tests names
// one byte per transfer against it, case-insensitive, with '/' taken as '\'.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | tdata                      | tuser            | tlast
// ---------+-----+----------------------------+------------------+------------
// s_axis   | in  | symbol[7:0]                | mode, no_char    | last
// m_axis   | out | matched, pattern_overflow  | -                | -
//
// One transfer is taken every cycle unless a stall on the output holds one. A
// result is registered once the last name transfer has left the input register,
// in which the byte sits while all pattern positions advance in parallel, star
// runs closed by a single carry chain one bit wider than the pattern bound.
// Reset clears the pattern, so names give no match until one is loaded.
// A stall on the output holds only a transfer that produces a result; the
// input register keeps taking transfers while the output register is free.
//
module wildcard_name_matcher
#(
    parameter int MAX_PATTERN = wnm_pkg::MAX_PATTERN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic [1:0] s_tuser,   // [0] mode, [1] no_char
    input  logic       s_tlast,   // last

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

    import wnm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = $clog2(MAX_PATTERN);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    logic             in_valid_reg;
    logic             in_mode_reg;
    logic [7:0]       in_sym_reg;
    logic             in_last_reg;
    logic             in_none_reg;

    logic [7:0]             fold_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] star_reg;
    logic [MAX_PATTERN-1:0] any_reg;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             too_reg;
    logic             too_next;
    logic             closed_reg;
    logic             closed_next;
    logic             name_reg;
    logic             name_next;
    logic             allstar_reg;
    logic             allstar_next;
    logic [MAX_PATTERN:0] act_reg;
    logic [MAX_PATTERN:0] act_next;
    logic [MAX_PATTERN:0] init_reg;
    logic [MAX_PATTERN:0] init_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_matched_reg;
    logic             out_over_reg;

    logic             produce;
    logic             adv;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [LEN_W-1:0] base_len;
    logic             res_matched;
    logic             res_over;
    logic [7:0]       sym_fold;

    logic [MAX_PATTERN-1:0] len_mask;
    logic [MAX_PATTERN:0]   le_mask;
    logic [MAX_PATTERN-1:0] star_m;
    logic [MAX_PATTERN-1:0] hit_vec;
    logic [MAX_PATTERN:0]   cur_vec;
    logic [MAX_PATTERN:0]   raw_vec;
    logic [MAX_PATTERN:0]   a_vec;
    logic [MAX_PATTERN:0]   b_vec;
    logic [MAX_PATTERN:0]   sum_vec;
    logic [MAX_PATTERN:0]   step_vec;

    // Handshake and flow.
    assign produce  = in_valid_reg && (in_mode_reg == MODE_NAME) && in_last_reg;
    assign adv      = in_valid_reg && (!produce || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    assign sym_fold = fold_byte(in_sym_reg);

    // Per-position compare against the current name byte.
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_pos
        assign len_mask[i] = LEN_W'(i) < len_reg;
        assign hit_vec[i]  = len_mask[i] && !star_reg[i]
                             && (any_reg[i] || (fold_reg[i] == sym_fold));
    end

    for (genvar j = 0; j <= MAX_PATTERN; j++)
    begin : g_le
        assign le_mask[j] = LEN_W'(j) <= len_reg;
    end

    // Advance the active set by one character, then close over star runs.
    // The sum carries spread each active star start along its run of stars.
    assign star_m   = star_reg & len_mask;
    assign cur_vec  = name_reg ? act_reg : init_reg;
    assign raw_vec  = {1'b0, cur_vec[MAX_PATTERN-1:0] & star_m}
                    | {cur_vec[MAX_PATTERN-1:0] & hit_vec, 1'b0};
    assign a_vec    = {1'b0, star_m};
    assign b_vec    = raw_vec & a_vec;
    assign sum_vec  = a_vec + b_vec;
    assign step_vec = raw_vec | (sum_vec ^ a_vec ^ b_vec);

    always_comb
    begin
        len_next     = len_reg;
        too_next     = too_reg;
        closed_next  = closed_reg;
        name_next    = name_reg;
        act_next     = act_reg;
        init_next    = init_reg;
        allstar_next = allstar_reg;
        wr_en        = 1'b0;
        res_matched  = 1'b0;
        res_over     = 1'b0;
        base_len     = closed_reg ? '0 : len_reg;
        wr_idx       = base_len[IDX_W-1:0];

        if (adv)
        begin
            if (in_mode_reg == MODE_PATTERN)
            begin
                name_next = 1'b0;
                if (closed_reg)
                begin
                    too_next     = 1'b0;
                    allstar_next = 1'b1;
                    init_next    = '0;
                    init_next[0] = 1'b1;
                end
                len_next = base_len;
                if (!in_none_reg)
                begin
                    if (base_len < MAX_LEN)
                    begin
                        wr_en    = 1'b1;
                        len_next = base_len + 1'b1;
                        if ((closed_reg || allstar_reg) && in_sym_reg == SYM_STAR)
                        begin
                            init_next[base_len + 1'b1] = 1'b1;
                        end
                        else
                        begin
                            allstar_next = 1'b0;
                        end
                    end
                    else
                    begin
                        too_next = 1'b1;
                    end
                end
                closed_next = in_last_reg;
            end
            else
            begin
                closed_next = 1'b1;
                act_next    = in_none_reg ? cur_vec : step_vec;
                name_next   = !in_last_reg;
                res_matched = (len_reg != '0) && !too_reg && act_next[len_reg];
                res_over    = too_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            len_reg       <= '0;
            too_reg       <= 1'b0;
            closed_reg    <= 1'b1;
            name_reg      <= 1'b0;
            allstar_reg   <= 1'b1;
            act_reg       <= '0;
            init_reg      <= {{MAX_PATTERN{1'b0}}, 1'b1};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            len_reg       <= len_next;
            too_reg       <= too_next;
            closed_reg    <= closed_next;
            name_reg      <= name_next;
            allstar_reg   <= allstar_next;
            act_reg       <= act_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= s_tuser[0];
            in_none_reg <= s_tuser[1];
            in_sym_reg  <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (adv && produce)
        begin
            out_matched_reg <= res_matched;
            out_over_reg    <= res_over;
        end
        if (wr_en)
        begin
            fold_reg[wr_idx] <= sym_fold;
            star_reg[wr_idx] <= (in_sym_reg == SYM_STAR);
            any_reg[wr_idx]  <= (in_sym_reg == SYM_ANY);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_over_reg, out_matched_reg};

    a_over_no_match : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> !m_tdata[0])
        else $error("overflowed pattern reported a match");

    a_result_loaded : assert property (@(posedge clk) disable iff (!rst_n)
        adv && produce |=> out_valid_reg)
        else $error("finished name gave no result");

    a_active_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        name_reg |-> ((act_reg & ~le_mask) == '0))
        else $error("active position beyond pattern length");

    a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= MAX_LEN)
        else $error("pattern length beyond bound");

endmodule

>>> verif/tb_wildcard_name_matcher.sv
// ----------------------------------------------------------------------------
// tb_wildcard_name_matcher: self-checking bench for the glob name matcher
// Loads patterns and streams names, predicts verdicts with its own tracker of
// active positions or takes them from the directed table, and compares every
// result transfer with the oldest prediction, idling at random on both sides but in the last run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wildcard_name_matcher;

    import wnm_pkg::*;

    localparam int MAXP        = MAX_PATTERN_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 6;
    localparam int DIR_ROWS    = 25;

    typedef logic [7:0] char_queue_t [$];

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] sym;
        logic       last;
        logic       no_char;
        logic       typed;
        logic       exp_match;
        logic       exp_ovf;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] symbol
    logic [1:0] s_tuser;   // [0] mode, [1] no_char
    logic       s_tlast;   // last
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [0] matched, [1] pattern_overflow, [7:2] zero

    // Glob tracker state.
    logic [7:0]  pat_bytes [MAXP];
    int          pat_len;
    logic        pat_too_long;
    logic        pat_closed;
    logic        name_open;
    logic [MAXP:0] live_pos;

    verdict_t    verdicts_due [$];
    int          mismatches;
    int          items_sent;
    int          cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    stim_row_t directed_rows [DIR_ROWS] = '{
        '{MODE_NAME,    8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        '{MODE_PATTERN, "A",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_PATTERN, "*",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_PATTERN, "/",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_PATTERN, "?",   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_NAME,    "a",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_NAME,    "B",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_NAME,    "\\",  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_NAME,    "z",   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_PATTERN, "*",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_PATTERN, "*",   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_NAME,    8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        '{MODE_PATTERN, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{MODE_NAME,    "x",   1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
        '{MODE_PATTERN, "a",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_PATTERN, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{MODE_PATTERN, "b",   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_NAME,    "A",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_NAME,    8'hA5, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{MODE_NAME,    "B",   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_PATTERN, "c",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_NAME,    "C",   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_NAME,    "x",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_PATTERN, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_NAME,    8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
    };

    wildcard_name_matcher DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        if (c == SYM_SLASH)
        begin
            return SYM_BACKSLASH;
        end
        if (c >= SYM_UPPER_A && c <= SYM_UPPER_Z)
        begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    // A live star also makes the position after it live.
    function automatic logic [MAXP:0] spread_stars(input logic [MAXP:0] s);
        logic [MAXP:0] r;
        r = s;
        for (int i = 0; i < pat_len; i++)
        begin
            if (r[i] && pat_bytes[i] == SYM_STAR)
            begin
                r[i + 1] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void step_name_char(input logic [7:0] c);
        logic [MAXP:0] nxt;
        nxt = '0;
        for (int i = 0; i < pat_len; i++)
        begin
            if (live_pos[i])
            begin
                if (pat_bytes[i] == SYM_STAR)
                begin
                    nxt[i] = 1'b1;
                end
                else if (pat_bytes[i] == SYM_ANY || fold_char(pat_bytes[i]) == fold_char(c))
                begin
                    nxt[i + 1] = 1'b1;
                end
            end
        end
        live_pos = spread_stars(nxt);
    endfunction

    function automatic void track_transfer(input logic mode, input logic [7:0] sym,
                                           input logic last, input logic no_char,
                                           output logic has_verdict, output verdict_t v);
        has_verdict = 1'b0;
        v = '0;
        if (mode == MODE_PATTERN)
        begin
            name_open = 1'b0;
            if (pat_closed)
            begin
                pat_len = 0;
                pat_too_long = 1'b0;
                pat_closed = 1'b0;
            end
            if (!no_char)
            begin
                if (pat_len < MAXP)
                begin
                    pat_bytes[pat_len] = sym;
                    pat_len++;
                end
                else
                begin
                    pat_too_long = 1'b1;
                end
            end
            if (last)
            begin
                pat_closed = 1'b1;
            end
            return;
        end
        pat_closed = 1'b1;
        if (!name_open)
        begin
            live_pos = '0;
            live_pos[0] = 1'b1;
            live_pos = spread_stars(live_pos);
            name_open = 1'b1;
        end
        if (!no_char)
        begin
            step_name_char(sym);
        end
        if (last)
        begin
            name_open = 1'b0;
            has_verdict = 1'b1;
            v.matched = pat_len > 0 && !pat_too_long && live_pos[pat_len];
            v.overflow = pat_too_long;
        end
    endfunction

    task automatic send_transfer(input logic mode, input logic [7:0] sym, input logic last,
                                 input logic no_char, input logic typed = 1'b0,
                                 input verdict_t typed_verdict = '0);
        logic     has_verdict;
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = sym;
        s_tuser  = {no_char, mode};
        s_tlast  = last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        track_transfer(mode, sym, last, no_char, has_verdict, v);
        if (has_verdict)
        begin
            verdicts_due.insert(verdicts_due.size(), typed ? typed_verdict : v);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_string(input logic mode, input char_queue_t q, input logic close);
        int   n;
        logic split_end;
        n = q.size();
        if (n == 0)
        begin
            send_transfer(mode, 8'($urandom_range(255)), close, 1'b1);
            return;
        end
        split_end = close && ($urandom_range(9) == 0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(11) == 0)
            begin
                send_transfer(mode, 8'($urandom_range(255)), 1'b0, 1'b1);
            end
            send_transfer(mode, q[i], close && !split_end && i == n - 1, 1'b0);
        end
        if (split_end)
        begin
            send_transfer(mode, 8'($urandom_range(255)), 1'b1, 1'b1);
        end
    endtask

    function automatic logic [7:0] random_name_char();
        case ($urandom_range(5))
            0: return 8'("a" + $urandom_range(3));
            1: return 8'("A" + $urandom_range(3));
            2: return SYM_SLASH;
            3: return SYM_BACKSLASH;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] respell(input logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
        begin
            return $urandom_range(1) ? (c | CASE_OFFSET) : (c & ~CASE_OFFSET);
        end
        if (c == SYM_SLASH || c == SYM_BACKSLASH)
        begin
            return $urandom_range(1) ? SYM_SLASH : SYM_BACKSLASH;
        end
        return c;
    endfunction

    function automatic char_queue_t make_pattern();
        char_queue_t p;
        int          len;
        int          lens [5] = '{MAXP - 1, MAXP, MAXP + 1, MAXP + 2, MAXP + 7};
        if ($urandom_range(19) == 0)
        begin
            len = lens[$urandom_range(4)];
        end
        else if ($urandom_range(14) == 0)
        begin
            len = 0;
        end
        else
        begin
            len = $urandom_range(1, 10);
        end
        repeat (len)
        begin
            case ($urandom_range(9))
                0, 1: p.insert(p.size(), SYM_STAR);
                2: p.insert(p.size(), SYM_ANY);
                3: p.insert(p.size(), SYM_SLASH);
                4: p.insert(p.size(), SYM_BACKSLASH);
                5, 6: p.insert(p.size(), 8'("a" + $urandom_range(3)));
                7: p.insert(p.size(), 8'("A" + $urandom_range(3)));
                default: p.insert(p.size(), 8'($urandom_range(255)));
            endcase
        end
        return p;
    endfunction

    // Builds a name that fits the pattern, then sometimes breaks it.
    function automatic char_queue_t make_name(input char_queue_t pat);
        char_queue_t nm;
        int          k;
        foreach (pat[i])
        begin
            if (pat[i] == SYM_STAR)
            begin
                k = $urandom_range(3);
                repeat (k) nm.insert(nm.size(), random_name_char());
            end
            else if (pat[i] == SYM_ANY)
            begin
                nm.insert(nm.size(), random_name_char());
            end
            else
            begin
                nm.insert(nm.size(), respell(pat[i]));
            end
        end
        if ($urandom_range(2) == 0)
        begin
            case ($urandom_range(2))
                0:
                begin
                    if (nm.size() > 0) nm[$urandom_range(nm.size() - 1)] = random_name_char();
                end
                1:
                begin
                    if (nm.size() > 0) nm.delete($urandom_range(nm.size() - 1));
                end
                default: nm.insert($urandom_range(nm.size()), random_name_char());
            endcase
        end
        return nm;
    endfunction

    task automatic run_random(input int upto);
        char_queue_t pat;
        char_queue_t nm;
        logic        keep_open;
        while (items_sent < upto)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_transfer(1'($urandom_range(1)), 8'($urandom_range(255)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            else
            begin
                pat = make_pattern();
                keep_open = pat.size() > 0 && $urandom_range(9) == 0;
                send_string(MODE_PATTERN, pat, !keep_open);
                repeat ($urandom_range(1, 6))
                begin
                    nm = make_name(pat);
                    send_string(MODE_NAME, nm, 1'b1);
                end
                if ($urandom_range(7) == 0)
                begin
                    nm = make_name(pat);
                    send_string(MODE_NAME, nm, 1'b0);
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("unexpected result transfer, tdata %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (m_tdata[0] !== want.matched)
                begin
                    $error("matched: expected %b, actual %b", want.matched, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[1] !== want.overflow)
                begin
                    $error("pattern_overflow: expected %b, actual %b",
                           want.overflow, m_tdata[1]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("wildcard_name_matcher: mismatch");
        $finish;
    end

    initial
    begin
        int base;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        mismatches    = 0;
        items_sent    = 0;
        pat_len       = 0;
        pat_too_long  = 1'b0;
        pat_closed    = 1'b1;
        name_open     = 1'b0;
        live_pos      = '0;
        send_idle_pct = 37;
        recv_idle_pct = 47;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            send_transfer(directed_rows[i].mode, directed_rows[i].sym,
                          directed_rows[i].last, directed_rows[i].no_char,
                          directed_rows[i].typed,
                          verdict_t'{directed_rows[i].exp_match, directed_rows[i].exp_ovf});
        end

        base = items_sent;
        run_random(base + 530);
        send_idle_pct = 47;
        recv_idle_pct = 37;
        run_random(base + 1070);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(base + 1600);
        s_tvalid = 1'b0;

        while (verdicts_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("wildcard_name_matcher: match");
        end
        else
        begin
            $display("wildcard_name_matcher: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
design/wnm_pkg.sv
design/wildcard_name_matcher.sv
verif/tb_wildcard_name_matcher.sv
